// File: hdl/scsg_pkg.sv
// ----------------------------------------------------------------------------
// scsg_pkg
// Types, codes and sizes shared by the s-curve step period generator.
// ----------------------------------------------------------------------------
package scsg_pkg;

    localparam int TABLE_ROWS = 256;
    localparam int ROW_W      = $clog2(TABLE_ROWS);
    localparam int ROWS_W     = $clog2(TABLE_ROWS + 1);
    localparam int RU_W       = (ROWS_W > 9) ? ROWS_W : 9;

    localparam int PER_W = 16;
    localparam int REP_W = 16;
    localparam int RAM_W = PER_W + REP_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_PULSES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_PULSES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PULSES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_ONLY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_TOTAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_JOG_START     = 3'd7;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PULSE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_PULSE = 2'd2;
    localparam logic [1:0] KIND_SKIP  = 2'd3;

    localparam logic [1:0] SEG_ACCEL = 2'd0;
    localparam logic [1:0] SEG_CONST = 2'd1;
    localparam logic [1:0] SEG_DECEL = 2'd2;
    localparam logic [1:0] SEG_IDLE  = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       row_index;
        logic [PER_W-1:0] row_period;
        logic [REP_W-1:0] row_repeat;
        logic             move_forward;
        logic             jog_held;
        logic             stop_request;
        logic             origin_hit;
        logic             end_hit;
    } t_in;

    typedef struct packed {
        logic [PER_W-1:0]   timer_period;
        logic               stop_motor;
        logic signed [31:0] position;
        logic [31:0]        pulses_done;
        logic [1:0]         segment;
    } t_out;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       row_index;
        logic [PER_W-1:0] row_period;
        logic [REP_W-1:0] row_repeat;
        logic             move_forward;
        logic             jog_held;
        logic             stop_request;
        logic             origin_hit;
        logic             end_hit;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/scsg_ram.sv
// ----------------------------------------------------------------------------
// scsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/scsg_front.sv
// ----------------------------------------------------------------------------
// scsg_front
// Input stage: takes each transaction, classifies it and hands it to the queue.
// ----------------------------------------------------------------------------
module scsg_front import scsg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_data,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_qent o_q_ent
);

    logic  r_valid;
    t_qent r_ent;
    t_qent w_ent;
    logic  w_accept;

    always_comb begin
        w_ent.row_index    = i_in_data.row_index;
        w_ent.row_period   = i_in_data.row_period;
        w_ent.row_repeat   = i_in_data.row_repeat;
        w_ent.move_forward = i_in_data.move_forward;
        w_ent.jog_held     = i_in_data.jog_held;
        w_ent.stop_request = i_in_data.stop_request;
        w_ent.origin_hit   = i_in_data.origin_hit;
        w_ent.end_hit      = i_in_data.end_hit;
        unique case (i_in_data.operation)
            OP_LOAD: begin
                // rows beyond the table are dropped
                w_ent.kind = (32'(i_in_data.row_index) < TABLE_ROWS) ? KIND_LOAD : KIND_SKIP;
            end
            OP_START: w_ent.kind = KIND_START;
            OP_PULSE: w_ent.kind = KIND_PULSE;
            OP_NONE:  w_ent.kind = KIND_SKIP;
        endcase
    end

    assign o_q_push   = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_q_ent    = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ent <= w_ent;
        end
    end

endmodule

// File: hdl/scsg_queue.sv
// ----------------------------------------------------------------------------
// scsg_queue
// Short register queue between the input stage and the execution stage.
// ----------------------------------------------------------------------------
module scsg_queue import scsg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_qent     i_ent,
    input  logic      i_pop,
    output t_qent     o_head,
    output t_q_status o_status
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

endmodule

// File: hdl/scsg_back.sv
// ----------------------------------------------------------------------------
// scsg_back
// Execution stage: configuration, period table, move state and result register.
// ----------------------------------------------------------------------------
module scsg_back import scsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_q_status,
    input  t_qent                 i_q_head,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ST1  = 3'd1;
    localparam logic [2:0] S_ST2  = 3'd2;
    localparam logic [2:0] S_PU2  = 3'd3;
    localparam logic [2:0] S_PU3  = 3'd4;

    localparam logic [1:0] PATH_KEEP   = 2'd0;
    localparam logic [1:0] PATH_CRUISE = 2'd1;
    localparam logic [1:0] PATH_ACCEL  = 2'd2;
    localparam logic [1:0] PATH_DECEL  = 2'd3;

    // configuration
    logic [31:0]      r_accel;
    logic [31:0]      r_const;
    logic [31:0]      r_total;
    logic [PER_W-1:0] r_cruise;
    logic [8:0]       r_rows_used;
    logic             r_const_only;
    logic             r_ign_total;
    logic             r_jog_start;
    logic [31:0]      r_acc_con;
    logic [31:0]      r_dec_base;
    logic [32:0]      w_acc_sum;
    logic [RU_W-1:0]  w_ru;
    logic [RU_W-1:0]  w_last_full;
    logic [ROW_W-1:0] w_last;

    // move state
    logic [2:0]         r_state, n_state;
    logic [31:0]        r_cnt, n_cnt;
    logic signed [31:0] r_pos, n_pos;
    logic               r_orig, n_orig;
    logic               r_endl, n_endl;
    logic [ROW_W-1:0]   r_arow, n_arow;
    logic [31:0]        r_arow_end, n_arow_end;
    logic [ROW_W-1:0]   r_drow, n_drow;
    logic [31:0]        r_drow_start, n_drow_start;
    logic               r_jog, n_jog;
    logic [PER_W-1:0]   r_period, n_period;
    logic               r_stop, n_stop;
    logic               r_jheld, n_jheld;
    logic               r_sreq, n_sreq;
    logic [1:0]         r_seg, n_seg;
    logic [1:0]         r_path, n_path;
    logic               r_step, n_step;
    logic [ROW_W-1:0]   r_addr, n_addr;

    // pulse decision
    logic [31:0]      w_c2;
    logic             w_stop2;
    logic             w_jog2;
    logic [1:0]       w_seg2;
    logic [1:0]       w_path2;
    logic             w_astep;
    logic             w_dstep;
    logic             w_step2;
    logic [31:0]      w_idx;
    logic [ROW_W-1:0] w_pu_addr;
    logic             w_orig_hit;
    logic             w_end_hit;

    // table memory
    logic             w_we;
    logic [ROW_W-1:0] w_waddr;
    logic [RAM_W-1:0] w_wdata;
    logic [ROW_W-1:0] w_raddr;
    logic [RAM_W-1:0] w_rdata;
    logic [PER_W-1:0] w_rd_per;
    logic [REP_W-1:0] w_rd_rep;

    // result register
    logic r_out_valid;
    t_out r_out;
    t_out w_out;
    logic w_out_load;
    logic w_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= '0;
            r_const      <= '0;
            r_total      <= '0;
            r_cruise     <= '0;
            r_rows_used  <= 9'd1;
            r_const_only <= 1'b0;
            r_ign_total  <= 1'b0;
            r_jog_start  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_PULSES:  r_accel      <= i_cfg_data;
                CFG_CONST_PULSES:  r_const      <= i_cfg_data;
                CFG_TOTAL_PULSES:  r_total      <= i_cfg_data;
                CFG_CRUISE_PERIOD: r_cruise     <= i_cfg_data[PER_W-1:0];
                CFG_ROWS_USED:     r_rows_used  <= i_cfg_data[8:0];
                CFG_CONSTANT_ONLY: r_const_only <= i_cfg_data[0];
                CFG_IGNORE_TOTAL:  r_ign_total  <= i_cfg_data[0];
                CFG_JOG_START:     r_jog_start  <= i_cfg_data[0];
            endcase
        end
    end

    // derived limits, registered from the configuration: r_acc_con, and r_dec_base from r_acc_con
    assign w_acc_sum = {1'b0, r_accel} + {1'b0, r_const};

    always_ff @(posedge i_clk) begin
        r_acc_con  <= w_acc_sum[32] ? 32'hFFFF_FFFF : w_acc_sum[31:0];
        r_dec_base <= r_accel + r_acc_con - 32'd1;
    end

    assign w_ru = RU_W'(r_rows_used);

    always_comb begin
        if (w_ru == '0) begin
            w_last_full = '0;
        end else if (w_ru > RU_W'(TABLE_ROWS)) begin
            w_last_full = RU_W'(TABLE_ROWS - 1);
        end else begin
            w_last_full = w_ru - RU_W'(1);
        end
    end

    assign w_last = w_last_full[ROW_W-1:0];

    scsg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_waddr  = ROW_W'(i_q_head.row_index);
    assign w_wdata  = {i_q_head.row_period, i_q_head.row_repeat};
    assign w_rd_per = w_rdata[RAM_W-1:REP_W];
    assign w_rd_rep = w_rdata[REP_W-1:0];

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = '0;
            S_ST1:   w_raddr = w_last;
            S_PU2:   w_raddr = w_pu_addr;
            default: w_raddr = r_addr;
        endcase
    end

    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_orig_hit = r_orig | i_q_head.origin_hit;
    assign w_end_hit  = r_endl | i_q_head.end_hit;

    // segment choice and row step for a pulse
    always_comb begin
        w_c2    = r_cnt;
        w_stop2 = r_stop;
        w_jog2  = r_jog;
        w_seg2  = SEG_DECEL;
        w_path2 = PATH_DECEL;
        if (r_jog) begin
            if (!r_jheld) begin
                w_jog2  = 1'b0;
                w_path2 = PATH_KEEP;
                if (r_const_only) begin
                    w_stop2 = 1'b1;
                    w_seg2  = SEG_CONST;
                end else begin
                    w_c2   = r_acc_con;
                    w_seg2 = SEG_DECEL;
                end
            end else if (!r_const_only && (r_cnt < r_accel)) begin
                w_path2 = PATH_ACCEL;
                w_seg2  = SEG_ACCEL;
            end else begin
                w_path2 = PATH_CRUISE;
                w_seg2  = SEG_CONST;
            end
        end else begin
            if ((r_cnt >= r_total) && !r_ign_total) begin
                w_stop2 = 1'b1;
            end
            if (r_sreq && (r_cnt < r_acc_con)) begin
                w_c2 = r_acc_con;
            end
            if (r_const_only ||
                ((r_const != '0) && (w_c2 >= r_accel) && (w_c2 < r_acc_con))) begin
                w_path2 = PATH_CRUISE;
                w_seg2  = SEG_CONST;
            end else if (w_c2 < r_accel) begin
                w_path2 = PATH_ACCEL;
                w_seg2  = SEG_ACCEL;
            end else begin
                w_path2 = PATH_DECEL;
                w_seg2  = SEG_DECEL;
            end
        end
        w_idx   = r_dec_base - w_c2;
        w_astep = (w_c2 >= r_arow_end) && (r_arow < w_last);
        w_dstep = (w_idx < r_drow_start) && (r_drow != '0);
        case (w_path2)
            PATH_ACCEL: begin
                w_step2   = w_astep;
                w_pu_addr = w_astep ? r_arow + ROW_W'(1) : r_arow;
            end
            PATH_DECEL: begin
                w_step2   = w_dstep;
                w_pu_addr = w_dstep ? r_drow - ROW_W'(1) : r_drow;
            end
            PATH_CRUISE, PATH_KEEP: begin
                w_step2   = 1'b0;
                w_pu_addr = r_addr;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_orig       = r_orig;
        n_endl       = r_endl;
        n_arow       = r_arow;
        n_arow_end   = r_arow_end;
        n_drow       = r_drow;
        n_drow_start = r_drow_start;
        n_jog        = r_jog;
        n_period     = r_period;
        n_stop       = r_stop;
        n_jheld      = r_jheld;
        n_sreq       = r_sreq;
        n_seg        = r_seg;
        n_path       = r_path;
        n_step       = r_step;
        n_addr       = r_addr;
        o_q_pop      = 1'b0;
        w_we         = 1'b0;
        w_out_load   = 1'b0;
        w_out        = '{timer_period: r_period, stop_motor: 1'b0, position: r_pos,
                         pulses_done: r_cnt, segment: SEG_IDLE};
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_q_head.kind) inside
                        KIND_LOAD, KIND_SKIP: begin
                            if (w_slot) begin
                                o_q_pop    = 1'b1;
                                w_we       = (i_q_head.kind == KIND_LOAD);
                                w_out_load = 1'b1;
                            end
                        end
                        KIND_START: begin
                            o_q_pop = 1'b1;
                            n_state = S_ST1;
                        end
                        KIND_PULSE: begin
                            o_q_pop = 1'b1;
                            n_pos   = i_q_head.move_forward ? r_pos + 32'sd1 : r_pos - 32'sd1;
                            n_orig  = w_orig_hit && !i_q_head.move_forward;
                            n_endl  = w_end_hit && i_q_head.move_forward;
                            n_cnt   = (r_cnt == 32'hFFFF_FFFF) ? r_cnt : r_cnt + 32'd1;
                            n_stop  = (w_orig_hit && !i_q_head.move_forward) ||
                                      (w_end_hit && i_q_head.move_forward);
                            n_jheld = i_q_head.jog_held;
                            n_sreq  = i_q_head.stop_request;
                            n_state = S_PU2;
                        end
                    endcase
                end
            end
            S_ST1: begin
                n_cnt      = '0;
                n_arow     = '0;
                n_arow_end = 32'(w_rd_rep);
                n_drow     = w_last;
                n_period   = w_rd_per;
                n_jog      = r_jog_start;
                n_addr     = w_last;
                n_state    = S_ST2;
            end
            S_ST2: begin
                if (w_slot) begin
                    n_drow_start = r_accel - 32'(w_rd_rep);
                    w_out_load   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PU2: begin
                n_cnt   = w_c2;
                n_stop  = w_stop2;
                n_jog   = w_jog2;
                n_seg   = w_seg2;
                n_path  = w_path2;
                n_step  = w_step2;
                n_addr  = w_pu_addr;
                n_state = S_PU3;
            end
            S_PU3: begin
                if (w_slot) begin
                    case (r_path)
                        PATH_ACCEL: begin
                            if (r_step) begin
                                n_arow     = r_arow + ROW_W'(1);
                                n_arow_end = r_arow_end + 32'(w_rd_rep);
                            end
                            n_period = w_rd_per;
                        end
                        PATH_DECEL: begin
                            if (r_step) begin
                                n_drow       = r_drow - ROW_W'(1);
                                n_drow_start = r_drow_start - 32'(w_rd_rep);
                            end
                            n_period = w_rd_per;
                        end
                        PATH_CRUISE: n_period = r_cruise;
                        PATH_KEEP: ;
                    endcase
                    w_out      = '{timer_period: n_period, stop_motor: r_stop, position: r_pos,
                                   pulses_done: r_cnt, segment: r_seg};
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_orig       <= 1'b0;
            r_endl       <= 1'b0;
            r_arow       <= '0;
            r_arow_end   <= '0;
            r_drow       <= '0;
            r_drow_start <= '0;
            r_jog        <= 1'b0;
            r_period     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pos        <= n_pos;
            r_orig       <= n_orig;
            r_endl       <= n_endl;
            r_arow       <= n_arow;
            r_arow_end   <= n_arow_end;
            r_drow       <= n_drow;
            r_drow_start <= n_drow_start;
            r_jog        <= n_jog;
            r_period     <= n_period;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop  <= n_stop;
        r_jheld <= n_jheld;
        r_sreq  <= n_sreq;
        r_seg   <= n_seg;
        r_path  <= n_path;
        r_step  <= n_step;
        r_addr  <= n_addr;
        if (w_out_load) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pu3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PU3) && !w_slot |=> (r_state == S_PU3) && $stable(r_addr))
        else $error("pulse result step left or moved its table address while stalled");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && !i_q_status.empty)
        else $error("queue popped outside idle or while empty");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten before it was taken");

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST1) |=> (r_state == S_ST2))
        else $error("start did not move on to its second table read");

endmodule

// File: hdl/scurve_step_period_generator.sv
// ----------------------------------------------------------------------------
// scurve_step_period_generator
// Per-pulse stepper timer period generator with a run-length s-curve table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_in_data  (t_in)
//  result    out        o_out_valid / i_out_ready   o_out_data (t_out)
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  pulse runs S_IDLE, S_PU2, S_PU3 and start S_IDLE, S_ST1, S_ST2 in the execution stage,
//  load S_IDLE only; an item reaches it through the input register and the queue
//  a pulse needs the decision state S_PU2 and the registered table read before S_PU3
//  synchronous active-low reset; table contents undefined until loaded
//  the queue and the result register let either side stall without loss
// ----------------------------------------------------------------------------
module scurve_step_period_generator import scsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      w_push;
    t_qent     w_push_ent;
    logic      w_pop;
    t_qent     w_head;
    t_q_status w_q_status;

    scsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_status.full),
        .o_q_push   (w_push),
        .o_q_ent    (w_push_ent)
    );

    scsg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_ent    (w_push_ent),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    scsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
